### rtl/fmacl_pkg.sv
// Shared types and constants for the first-match ACL table.
// No dependencies; imported by every module under rtl/.
package fmacl_pkg;

  localparam int RULE_ENTRIES = 16;
  localparam int ADDR_W  = 32;
  localparam int ACT_W   = 8;
  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 5;
  localparam int CNT_W   = $clog2(RULE_ENTRIES + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] src_mask;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] dst_mask;
    logic [ACT_W-1:0]  code;
  } rule_t;

  typedef struct packed {
    logic load;   // take the broadcast key as a new rule
    logic shift;  // take the neighbor's rule (close-up after a remove)
    logic probe;  // compare the key against the held rule
  } cell_ctl_t;

endpackage

### rtl/first_match_acl_table.sv
// Top level of the first-match ACL table: command port, rule-cell chain,
// priority select and result register. Uses fmacl_pkg, fmacl_cell, fmacl_select.
//
//  channel    | handshake                | payload
//  -----------+--------------------------+-------------------------------------
//  command    | start / busy             | op, src_addr, src_mask, dst_addr,
//             |                          | dst_mask, rule_action, entry_index
//  config     | reject_action_we         | reject_action
//  result     | done (one-cycle strobe)  | action, hit, status, rule_total
//
// An item is taken when start is high and busy is low; busy is then high for
// one cycle while the cells update or compare, and a new item can be taken
// while the previous one is still on its way to the result register. The
// item passes the exec register (the cells), then stage2 (the priority
// select into the result register); done rises as the result loads. rst
// (synchronous) empties the table and sets reject_action to 0. Results
// cannot be held off by the receiver.
module first_match_acl_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [fmacl_pkg::OP_W-1:0]    op,
  input  logic [fmacl_pkg::ADDR_W-1:0]  src_addr,
  input  logic [fmacl_pkg::ADDR_W-1:0]  src_mask,
  input  logic [fmacl_pkg::ADDR_W-1:0]  dst_addr,
  input  logic [fmacl_pkg::ADDR_W-1:0]  dst_mask,
  input  logic [fmacl_pkg::ACT_W-1:0]   rule_action,
  input  logic [fmacl_pkg::POS_W-1:0]   entry_index,
  input  logic                          reject_action_we,
  input  logic [fmacl_pkg::ACT_W-1:0]   reject_action,
  output logic                          done,
  output logic [fmacl_pkg::ACT_W-1:0]   action,
  output logic                          hit,
  output logic [fmacl_pkg::STAT_W-1:0]  status,
  output logic [fmacl_pkg::TOTAL_W-1:0] rule_total
);
  import fmacl_pkg::*;

  logic                   accept;
  logic                   exec;
  logic                   stage2;
  op_t                    op_q;
  op_t                    op_s2;
  logic [POS_W-1:0]       pos_q;
  rule_t                  key_q;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  status_t                status_c;
  status_t                status_s2;
  logic [ACT_W-1:0]       reject_code;
  logic                   full;
  logic                   pos_ok;

  cell_ctl_t                           ctl   [RULE_ENTRIES];
  rule_t                               rules [RULE_ENTRIES];
  logic [RULE_ENTRIES-1:0]             hits;
  logic [RULE_ENTRIES-1:0][ACT_W-1:0]  codes;
  logic                                sel_hit;
  logic [ACT_W-1:0]                    sel_code;

  assign accept = start && !exec;
  assign busy   = exec;
  assign full   = count == CNT_W'(RULE_ENTRIES);
  assign pos_ok = CMP_W'(pos_q) < CMP_W'(count);

  always_comb begin
    count_next = count;
    status_c   = ST_OK;
    if (exec) begin
      case (op_q)
        OP_APPEND: begin
          if (full) status_c = ST_FULL;
          else      count_next = count + CNT_W'(1);
        end
        OP_REMOVE: begin
          if (pos_ok) count_next = count - CNT_W'(1);
          else        status_c = ST_BAD_POS;
        end
        OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < RULE_ENTRIES; i++) begin : g_cell
    assign ctl[i].load  = exec && (op_q == OP_APPEND) && !full && (count == CNT_W'(i));
    assign ctl[i].shift = exec && (op_q == OP_REMOVE) && pos_ok &&
                          (CMP_W'(i) >= CMP_W'(pos_q)) && (CNT_W'(i + 1) < count);
    assign ctl[i].probe = exec && (op_q == OP_CHECK) && (CNT_W'(i) < count);
    assign codes[i]     = rules[i].code;

    if (i == RULE_ENTRIES - 1) begin : g_last
      // last slot never shifts in; feed back its own rule
      fmacl_cell u_cell (
        .clk       (clk),
        .ctl       (ctl[i]),
        .key       (key_q),
        .next_rule (rules[i]),
        .rule      (rules[i]),
        .hit       (hits[i])
      );
    end else begin : g_mid
      fmacl_cell u_cell (
        .clk       (clk),
        .ctl       (ctl[i]),
        .key       (key_q),
        .next_rule (rules[i+1]),
        .rule      (rules[i]),
        .hit       (hits[i])
      );
    end
  end

  fmacl_select u_select (
    .hits    (hits),
    .codes   (codes),
    .any_hit (sel_hit),
    .code    (sel_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      exec        <= 1'b0;
      stage2      <= 1'b0;
      done        <= 1'b0;
      count       <= '0;
      reject_code <= '0;
    end else begin
      exec   <= accept;
      stage2 <= exec;
      done   <= stage2;
      count  <= count_next;
      if (reject_action_we) reject_code <= reject_action;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op_t'(op);
      pos_q <= entry_index;
      key_q <= '{src: src_addr, src_mask: src_mask, dst: dst_addr,
                 dst_mask: dst_mask, code: rule_action};
    end
    if (exec) begin
      op_s2     <= op_q;
      status_s2 <= status_c;
    end
    if (stage2) begin
      if (op_s2 == OP_CHECK) begin
        action <= sel_hit ? sel_code : reject_code;
        hit    <= sel_hit;
      end else begin
        action <= '0;
        hit    <= 1'b0;
      end
      status     <= status_s2;
      rule_total <= TOTAL_W'(count);
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##2 done)
    else $error("no result strobe after accepted item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(RULE_ENTRIES))
    else $error("rule count beyond table depth");

  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (status == ST_OK))
    else $error("hit reported with error status");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

endmodule

### rtl/fmacl_cell.sv
// One rule slot of the ACL chain: holds a rule, shifts from its neighbor,
// and registers a masked compare against the broadcast key. Uses fmacl_pkg.
module fmacl_cell (
  input  logic               clk,
  input  fmacl_pkg::cell_ctl_t ctl,
  input  fmacl_pkg::rule_t   key,
  input  fmacl_pkg::rule_t   next_rule,
  output fmacl_pkg::rule_t   rule,
  output logic               hit
);
  import fmacl_pkg::*;

  logic src_eq;
  logic dst_eq;

  assign src_eq = ((key.src ^ rule.src) & rule.src_mask) == '0;
  assign dst_eq = ((key.dst ^ rule.dst) & rule.dst_mask) == '0;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rule <= key;
    end else if (ctl.shift) begin
      rule <= next_rule;
    end
    hit <= ctl.probe && src_eq && dst_eq;
  end

endmodule

### rtl/fmacl_select.sv
// Priority select over the registered cell hits: lowest slot wins.
// Uses fmacl_pkg.
module fmacl_select (
  input  logic [fmacl_pkg::RULE_ENTRIES-1:0]                       hits,
  input  logic [fmacl_pkg::RULE_ENTRIES-1:0][fmacl_pkg::ACT_W-1:0] codes,
  output logic                                                     any_hit,
  output logic [fmacl_pkg::ACT_W-1:0]                              code
);
  import fmacl_pkg::*;

  logic [RULE_ENTRIES-1:0] first;

  // isolate lowest set bit
  assign first   = hits & (~hits + RULE_ENTRIES'(1));
  assign any_hit = |hits;

  always_comb begin
    code = '0;
    for (int i = 0; i < RULE_ENTRIES; i++) begin
      code = code | (codes[i] & {ACT_W{first[i]}});
    end
  end

endmodule
